// ===== design/dpc_pkg.sv =====
// Shared types, widths, register codes and the disk offset table for disk_pattern_code.
`default_nettype none

package dpc_pkg;

    localparam int PIX_W        = 8;
    localparam int CODE_W       = 18;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 10;
    localparam int WIN_N        = 9;
    localparam int STORE_LINES  = 8;
    localparam int SLOT_W       = 3;
    localparam int OFFSET_REACH = 4;
    localparam int PAIR_COUNT   = 18;
    localparam int NP_W         = 5;
    localparam int MARGIN_W     = 7;
    localparam int IWIDTH_W     = 11;
    localparam int FIFO_DEPTH   = 4;

    localparam int DEF_MAX_LINE_PIXELS = 1024;

    localparam int CFG_DATA_W = 12;
    localparam int MIN_SIZE   = 9;
    localparam int MAX_HEIGHT = 4095;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_BORDER_MARGIN = 2'd2,
        CFG_NUM_PAIRS     = 2'd3
    } cfg_index_t;

    localparam logic [IWIDTH_W-1:0] RST_IMAGE_WIDTH   = 11'd100;
    localparam logic [ROW_W-1:0]    RST_IMAGE_HEIGHT  = 12'd100;
    localparam logic [MARGIN_W-1:0] RST_BORDER_MARGIN = 7'd4;
    localparam logic [NP_W-1:0]     RST_NUM_PAIRS     = 5'd18;

    // Offset pair b compares pixel (+v,+u) against (-v,-u) around the centre.
    localparam int OFF_V [PAIR_COUNT] = '{2, 2, 2, 1, 0, -1, 3, 2, 1, -1, -2, -3,
                                          4, 4, 4, 2, 0, -2};
    localparam int OFF_U [PAIR_COUNT] = '{-1, 0, 1, 2, 2, 2, 1, 2, 3, 3, 2, 1,
                                          -2, 0, 2, 4, 4, 4};

    typedef logic [STORE_LINES-1:0][PIX_W-1:0] column_t;

    typedef struct packed {
        logic              frame_last;
        logic [COL_W-1:0]  center_col;
        logic [ROW_W-1:0]  center_row;
        logic [CODE_W-1:0] code;
    } result_t;

endpackage

`default_nettype wire

// ===== design/dpc_line_mem.sv =====
// Line store: eight lines packed per column word, read then written back with the new pixel.
`default_nettype none

module dpc_line_mem #(
    parameter int DEPTH = dpc_pkg::DEF_MAX_LINE_PIXELS
) (
    input  wire logic                               clk,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
    input  wire logic                               wb_en,
    input  wire logic [$clog2(DEPTH)-1:0]           wb_addr,
    input  wire logic [dpc_pkg::PIX_W-1:0]          wb_px,
    input  wire logic [dpc_pkg::SLOT_W-1:0]         wb_slot,
    output dpc_pkg::column_t                        column
);
    import dpc_pkg::*;

    column_t mem [DEPTH];
    column_t rdata_reg;
    column_t merged;

    // Byte k of a word holds line slot k; rotate so the oldest line comes first.
    always_comb
    begin
        for (int k = 0; k < STORE_LINES; k++)
        begin
            column[k] = rdata_reg[SLOT_W'(wb_slot + SLOT_W'(k))];
            merged[k] = (SLOT_W'(k) == wb_slot) ? wb_px : rdata_reg[k];
        end
    end

    // Consecutive columns differ in address, so the write-back never hits the read in flight.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wb_en)
        begin
            mem[wb_addr] <= merged;
        end
    end

endmodule

`default_nettype wire

// ===== design/dpc_window_code.sv =====
// 9x9 pixel window shift register and the offset-pair comparators that form the code.
`default_nettype none

module dpc_window_code (
    input  wire logic                          clk,
    input  wire logic                          shift_en,
    input  dpc_pkg::column_t                   column,
    input  wire logic [dpc_pkg::PIX_W-1:0]     px,
    input  wire logic [dpc_pkg::NP_W-1:0]      np,
    output logic      [dpc_pkg::CODE_W-1:0]    code
);
    import dpc_pkg::*;

    localparam int CTR = OFFSET_REACH;

    logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] win_reg;
    logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] win_next;

    always_comb
    begin
        for (int a = 0; a < WIN_N; a++)
        begin
            for (int j = 0; j < WIN_N - 1; j++)
            begin
                win_next[a][j] = win_reg[a][j+1];
            end
        end
        for (int k = 0; k < STORE_LINES; k++)
        begin
            win_next[k][WIN_N-1] = column[k];
        end
        win_next[WIN_N-1][WIN_N-1] = px;
    end

    always_comb
    begin
        code = '0;
        for (int b = 0; b < PAIR_COUNT; b++)
        begin
            code[b] = (NP_W'(b) < np) &&
                      (win_next[CTR+OFF_V[b]][CTR+OFF_U[b]] >
                       win_next[CTR-OFF_V[b]][CTR-OFF_U[b]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dpc_out_fifo.sv =====
// Small result queue that parts the input side from the output handshake.
`default_nettype none

module dpc_out_fifo (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      push,
    input  dpc_pkg::result_t                               push_item,
    input  wire logic                                      pop,
    output dpc_pkg::result_t                               head_item,
    output logic                                           not_empty,
    output logic [$clog2(dpc_pkg::FIFO_DEPTH+1)-1:0]       count
);
    import dpc_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    result_t       slots [FIFO_DEPTH];
    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [PW-1:0] tail_reg;
    logic [PW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head_item = slots[head_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb
    begin
        head_next  = do_pop ? PW'(head_reg + 1'b1) : head_reg;
        tail_next  = push ? PW'(tail_reg + 1'b1) : tail_reg;
        count_next = CW'(count_reg + CW'(push) - CW'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[tail_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/disk_pattern_code.sv =====
// Top level: raster counters, configuration, read-modify-write pipeline and output queue.
// Throughput: one pixel per cycle while s_tready is high; the line store is read at accept
// and written back in the next cycle, a single read port and a single write port per cycle.
// A code is pushed in the cycle after its last pixel is accepted and shows on m_tvalid
// in the cycle after the push.
// Reset: counters and queue clear, registers load 100, 100, 4, 18; line store is not cleared.
`default_nettype none

module disk_pattern_code #(
    parameter int MAX_LINE_PIXELS = dpc_pkg::DEF_MAX_LINE_PIXELS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] pixel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [39:0]                            m_tdata,   // [17:0] code, [29:18] center_row,
                                                              // [39:30] center_col
    output logic                                   m_tlast,   // frame_last
    input  wire logic                              cfg_wr_en,
    input  dpc_pkg::cfg_index_t                    cfg_index,
    input  wire logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dpc_pkg::*;

    localparam int AW  = $clog2(MAX_LINE_PIXELS);
    localparam int WW  = ($clog2(MAX_LINE_PIXELS + 1) > IWIDTH_W) ?
                         $clog2(MAX_LINE_PIXELS + 1) : IWIDTH_W;
    localparam int CSW = WW + 1;
    localparam int RSW = ROW_W + 2;
    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    // configuration
    logic [IWIDTH_W-1:0] image_width_reg;
    logic [ROW_W-1:0]    image_height_reg;
    logic [MARGIN_W-1:0] border_margin_reg;
    logic [NP_W-1:0]     num_pairs_reg;

    // raster position
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [AW-1:0]    col_addr_reg;
    logic [AW-1:0]    col_addr_next;

    // write-back stage
    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_last_reg;

    logic             accept;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [MARGIN_W-1:0] m_eff;
    logic [NP_W-1:0]  np_eff;
    logic [CSW-1:0]   c_ext;
    logic [CSW-1:0]   w_ext;
    logic [CSW-1:0]   mc_ext;
    logic [RSW-1:0]   r_ext;
    logic [RSW-1:0]   h_ext;
    logic [RSW-1:0]   mr_ext;
    logic             row_in;
    logic             col_in;
    logic             emit;
    logic             is_last;
    logic             line_wrap;
    logic [RSW-1:0]   row_inc;

    column_t          column;
    logic [CODE_W-1:0] code;
    result_t          push_item;
    result_t          head_item;
    logic             fifo_push;
    logic             fifo_pop;
    logic [FCW-1:0]   fifo_count;

    assign accept = s_tvalid && s_tready;

    // effective register values
    always_comb
    begin
        if (image_width_reg < IWIDTH_W'(MIN_SIZE))
        begin
            w_eff = WW'(MIN_SIZE);
        end
        else if (WW'(image_width_reg) > WW'(MAX_LINE_PIXELS))
        begin
            w_eff = WW'(MAX_LINE_PIXELS);
        end
        else
        begin
            w_eff = WW'(image_width_reg);
        end
        h_eff  = (image_height_reg < ROW_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : image_height_reg;
        m_eff  = (border_margin_reg < MARGIN_W'(OFFSET_REACH)) ?
                 MARGIN_W'(OFFSET_REACH) : border_margin_reg;
        np_eff = (num_pairs_reg > NP_W'(PAIR_COUNT)) ? NP_W'(PAIR_COUNT) : num_pairs_reg;
    end

    // interior test for centre (row-4, col-4) and raster advance
    always_comb
    begin
        c_ext  = CSW'(col_count_reg);
        w_ext  = CSW'(w_eff);
        mc_ext = CSW'(m_eff);
        r_ext  = RSW'(row_count_reg);
        h_ext  = RSW'(h_eff);
        mr_ext = RSW'(m_eff);

        row_in  = (r_ext >= mr_ext + RSW'(OFFSET_REACH)) &&
                  (r_ext + mr_ext < h_ext + RSW'(OFFSET_REACH));
        col_in  = (c_ext >= mc_ext + CSW'(OFFSET_REACH)) &&
                  (c_ext + mc_ext < w_ext + CSW'(OFFSET_REACH));
        emit    = row_in && col_in;
        is_last = (r_ext + mr_ext + RSW'(1) == h_ext + RSW'(OFFSET_REACH)) &&
                  (c_ext + mc_ext + CSW'(1) == w_ext + CSW'(OFFSET_REACH));

        line_wrap = (c_ext + CSW'(1) >= w_ext);
        row_inc   = r_ext + RSW'(1);

        if (line_wrap)
        begin
            col_count_next = '0;
            col_addr_next  = '0;
            row_count_next = (row_inc >= h_ext) ? '0 : ROW_W'(row_inc);
        end
        else
        begin
            col_count_next = COL_W'(col_count_reg + 1'b1);
            // track col_count modulo the store depth, including the 10-bit wrap
            if ((col_count_reg == '1) || (col_addr_reg == AW'(MAX_LINE_PIXELS - 1)))
            begin
                col_addr_next = '0;
            end
            else
            begin
                col_addr_next = AW'(col_addr_reg + 1'b1);
            end
            row_count_next = (r_ext >= h_ext) ? '0 : row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            border_margin_reg <= RST_BORDER_MARGIN;
            num_pairs_reg     <= RST_NUM_PAIRS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[IWIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[ROW_W-1:0];
                CFG_BORDER_MARGIN: border_margin_reg <= cfg_data[MARGIN_W-1:0];
                CFG_NUM_PAIRS:     num_pairs_reg     <= cfg_data[NP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            col_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s1_emit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit;
            if (accept)
            begin
                row_count_reg <= row_count_next;
                col_count_reg <= col_count_next;
                col_addr_reg  <= col_addr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= col_addr_reg;
            s1_px_reg   <= s_tdata[PIX_W-1:0];
            s1_slot_reg <= row_count_reg[SLOT_W-1:0];
            s1_row_reg  <= ROW_W'(row_count_reg - ROW_W'(OFFSET_REACH));
            s1_col_reg  <= COL_W'(col_count_reg - COL_W'(OFFSET_REACH));
            s1_last_reg <= is_last;
        end
    end

    dpc_line_mem #(
        .DEPTH (MAX_LINE_PIXELS)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_addr_reg),
        .wb_en   (s1_valid_reg),
        .wb_addr (s1_addr_reg),
        .wb_px   (s1_px_reg),
        .wb_slot (s1_slot_reg),
        .column  (column)
    );

    dpc_window_code u_window (
        .clk      (clk),
        .shift_en (s1_valid_reg),
        .column   (column),
        .px       (s1_px_reg),
        .np       (np_eff),
        .code     (code)
    );

    always_comb
    begin
        push_item.code       = code;
        push_item.center_row = s1_row_reg;
        push_item.center_col = s1_col_reg;
        push_item.frame_last = s1_last_reg;
    end

    assign fifo_push = s1_valid_reg && s1_emit_reg;
    assign fifo_pop  = m_tvalid && m_tready;

    dpc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_item (push_item),
        .pop       (fifo_pop),
        .head_item (head_item),
        .not_empty (m_tvalid),
        .count     (fifo_count)
    );

    // hold input while queued results plus the one in flight could fill the queue
    assign s_tready = (fifo_count + FCW'(s1_emit_reg)) < FCW'(FIFO_DEPTH);

    assign m_tdata = {head_item.center_col, head_item.center_row, head_item.code};
    assign m_tlast = head_item.frame_last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_count < FCW'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_rmw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (col_addr_reg != s1_addr_reg))
        else $error("line store read collides with pending write-back");

    a_emit_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> ##1 m_tvalid)
        else $error("interior code not queued");

endmodule

`default_nettype wire
